FILE: hw/rtl/bcpc_pkg.sv
// Shared types, constants and lookup functions for the BLDC commutation block.
package bcpc_pkg;

  // Width of the signed sector step counter
  localparam int POSITION_WIDTH = 32;

  // Error and torque datapath widths
  localparam int ERR_W = POSITION_WIDTH + 1;
  localparam int DE_W  = ERR_W + 5;
  localparam int TQ_W  = ERR_W + 15;

  // Stream and config port widths
  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Motor constants
  localparam int SECTORS     = 6;
  localparam int DERIV_SCALE = 10;

  // Config reset values
  localparam logic [15:0] LIMIT_RESET = 16'd2000;
  localparam logic [7:0]  KP_RESET    = 8'd75;
  localparam logic [7:0]  KD_RESET    = 8'd20;

  localparam logic [2:0] SECTOR_INVALID = 3'd7;

  // Floor quotient and remainder of the step counter extremes by six
  localparam longint PosMinL = -(longint'(1) <<< (POSITION_WIDTH - 1));
  localparam longint PosMaxL = (longint'(1) <<< (POSITION_WIDTH - 1)) - 1;
  localparam longint QMinT   = PosMinL / SECTORS;
  localparam longint RMinT   = PosMinL % SECTORS;
  localparam longint QMinL   = (RMinT < 0) ? QMinT - 1 : QMinT;
  localparam longint RMinL   = (RMinT < 0) ? RMinT + SECTORS : RMinT;
  localparam longint QMaxL   = PosMaxL / SECTORS;
  localparam longint RMaxL   = PosMaxL % SECTORS;

  localparam logic [POSITION_WIDTH-1:0] Q_MIN = POSITION_WIDTH'(QMinL);
  localparam logic [2:0]                R_MIN = 3'(RMinL);
  localparam logic [POSITION_WIDTH-1:0] Q_MAX = POSITION_WIDTH'(QMaxL);
  localparam logic [2:0]                R_MAX = 3'(RMaxL);

  // Item kind carried in tuser
  typedef enum logic {
    MODE_HALL = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  // Config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN = 3'd0,
    CFG_TARGET = 3'd1,
    CFG_KP     = 3'd2,
    CFG_KD     = 3'd3,
    CFG_LIMIT  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]  origin;
    logic [15:0] target;
    logic [7:0]  kp;
    logic [7:0]  kd;
    logic [15:0] limit;
  } cfg_t;

  // Position tracker view
  typedef struct packed {
    logic [2:0]                last_rotor;
    logic [POSITION_WIDTH-1:0] step_next;
    logic [POSITION_WIDTH-1:0] revs;
  } pos_t;

  // PD loop view: freshly computed and currently held values
  typedef struct packed {
    logic [15:0] torque_new;
    logic        reverse_new;
    logic [15:0] torque_cur;
    logic        reverse_cur;
  } pd_t;

  // Value 0..19 reduced mod 6
  function automatic logic [2:0] mod6(input logic [4:0] v);
    logic [4:0] t;
    t = v;
    if (t >= 5'(2 * SECTORS)) t = t - 5'(2 * SECTORS);
    if (t >= 5'(SECTORS)) t = t - 5'(SECTORS);
    return t[2:0];
  endfunction

  // Hall code to rotor sector, invalid codes give 7
  function automatic logic [2:0] hall_sector(input logic [2:0] hall);
    logic [2:0] s;
    case (hall)
      3'd1:    s = 3'd5;
      3'd2:    s = 3'd3;
      3'd3:    s = 3'd4;
      3'd4:    s = 3'd1;
      3'd5:    s = 3'd0;
      3'd6:    s = 3'd2;
      default: s = SECTOR_INVALID;
    endcase
    return s;
  endfunction

  // Drive state to six-bit phase switch pattern
  function automatic logic [5:0] phase_bits(input logic [2:0] state);
    logic [5:0] p;
    case (state)
      3'd0:    p = 6'h12;
      3'd1:    p = 6'h18;
      3'd2:    p = 6'h09;
      3'd3:    p = 6'h21;
      3'd4:    p = 6'h24;
      3'd5:    p = 6'h06;
      default: p = 6'h00;
    endcase
    return p;
  endfunction

  // Pattern for a rotor sector with a +2 or -2 lead
  function automatic logic [5:0] pattern_for(input logic [2:0] sector,
                                             input logic [2:0] origin,
                                             input logic       reverse);
    logic [4:0] idx;
    idx = 5'(sector) + 5'(2 * SECTORS) - 5'(origin);
    idx = reverse ? idx - 5'd2 : idx + 5'd2;
    return phase_bits(mod6(idx));
  endfunction

endpackage

FILE: hw/rtl/bcpc_pos_track.sv
// Sector step counter with incremental revolution tracking.
module bcpc_pos_track (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              upd_i,
  input  logic [2:0]        sector_i,
  output bcpc_pkg::pos_t    pos_o
);
  import bcpc_pkg::*;

  localparam int P = POSITION_WIDTH;

  logic [2:0]          last_q, last_d;
  logic [2:0]          rem_q, rem_d;
  logic signed [P-1:0] step_q, step_d;
  logic signed [P-1:0] quot_q, quot_d;
  logic signed [P-1:0] revs_q, revs_d;

  logic [2:0]          sector_gap;
  logic signed [3:0]   delta;
  logic signed [P:0]   sum;
  logic signed [P-1:0] base_q;
  logic [2:0]          base_r;
  logic signed [3:0]   off;
  logic signed [4:0]   rsum;
  logic signed [P-1:0] quot_new;
  logic [2:0]          rem_new;
  logic                rnd;

  // Step delta, then floor quotient and remainder kept as step = 6*quot + rem
  always_comb begin
    sector_gap = mod6(5'(sector_i) + 5'(SECTORS) - 5'(last_q));
    delta      = $signed({1'b0, sector_gap});
    if (sector_gap > 3'd3) delta = $signed({1'b0, sector_gap}) - 4'(SECTORS);

    sum = (P + 1)'(step_q) + (P + 1)'(delta);

    base_q = quot_q;
    base_r = rem_q;
    off    = delta;
    if (!sum[P] && sum[P-1]) begin
      // wrapped past the top: now just above the most negative value
      base_q = $signed(Q_MIN);
      base_r = R_MIN;
      off    = $signed({1'b0, sum[2:0]});
    end else if (sum[P] && !sum[P-1]) begin
      // wrapped past the bottom: now just below the most positive value
      base_q = $signed(Q_MAX);
      base_r = R_MAX;
      off    = $signed({1'b0, sum[2:0]}) - 4'sd7;
    end

    rsum = $signed({2'b00, base_r}) + 5'(off);
    if (rsum[4]) begin
      rem_new  = 3'(rsum + 5'(SECTORS));
      quot_new = base_q - P'(1);
    end else if (rsum >= 5'(SECTORS)) begin
      rem_new  = 3'(rsum - 5'(SECTORS));
      quot_new = base_q + P'(1);
    end else begin
      rem_new  = rsum[2:0];
      quot_new = base_q;
    end

    // truncate toward zero
    rnd = quot_new[P-1] && (rem_new != 3'd0);

    last_d = last_q;
    step_d = step_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    revs_d = revs_q;
    if (upd_i) begin
      last_d = sector_i;
      step_d = sum[P-1:0];
      quot_d = quot_new;
      rem_d  = rem_new;
      revs_d = quot_new + P'(rnd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      step_q <= '0;
      quot_q <= '0;
      rem_q  <= '0;
      revs_q <= '0;
    end else begin
      last_q <= last_d;
      step_q <= step_d;
      quot_q <= quot_d;
      rem_q  <= rem_d;
      revs_q <= revs_d;
    end
  end

  assign pos_o.last_rotor = last_q;
  assign pos_o.step_next  = step_d;
  assign pos_o.revs       = revs_q;

endmodule

FILE: hw/rtl/bcpc_pd_loop.sv
// PD position loop: revolution error, derivative, torque and saturation.
module bcpc_pd_loop (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             tick_i,
  input  logic [bcpc_pkg::POSITION_WIDTH-1:0] revs_i,
  input  bcpc_pkg::cfg_t                   cfg_i,
  output bcpc_pkg::pd_t                    pd_o
);
  import bcpc_pkg::*;

  logic signed [ERR_W-1:0] prev_q;
  logic                    reverse_q;
  logic [15:0]             torque_q;

  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W:0]   diff;
  logic signed [DE_W-1:0]  de;
  logic signed [ERR_W+8:0] p_term;
  logic signed [DE_W+8:0]  d_term;
  logic signed [TQ_W-1:0]  torque;
  logic [TQ_W-1:0]         mag;
  logic                    neg;
  logic [15:0]             level;

  // Error, derivative and gain products
  always_comb begin
    err    = ERR_W'($signed(cfg_i.target)) - ERR_W'($signed(revs_i));
    diff   = (ERR_W + 1)'(err) - (ERR_W + 1)'(prev_q);
    de     = DE_W'(diff) * $signed(DE_W'(DERIV_SCALE));
    p_term = $signed({1'b0, cfg_i.kp}) * err;
    d_term = $signed({1'b0, cfg_i.kd}) * de;
  end

  // Sign picks the lead, magnitude saturates at the limit
  always_comb begin
    torque = TQ_W'(p_term) + TQ_W'(d_term);
    neg    = torque[TQ_W-1];
    mag    = neg ? TQ_W'(-torque) : TQ_W'(torque);
    level  = (mag > TQ_W'(cfg_i.limit)) ? cfg_i.limit : mag[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      reverse_q <= 1'b0;
      torque_q  <= '0;
    end else if (tick_i) begin
      prev_q    <= err;
      reverse_q <= neg;
      torque_q  <= level;
    end
  end

  assign pd_o.torque_new  = level;
  assign pd_o.reverse_new = neg;
  assign pd_o.torque_cur  = torque_q;
  assign pd_o.reverse_cur = reverse_q;

endmodule

FILE: hw/rtl/bldc_commutation_position_control.sv
// Top level of the six-step BLDC commutator with PD position loop.
//
// Each request on the slave stream is either a hall change (tuser 0, hall
// levels in tdata[2:0]) or a control tick (tuser 1), and it yields exactly
// one result on the master stream. One request is taken every clock cycle
// while results drain; an accepted request is loaded into the input register
// and, once the result register is free or being drained, its result into
// the result register. While a result waits, one more request is taken into
// the input register and then the slave side stalls until the result is
// taken. The throughput is set by the single pass from the input register
// through the step tracker or the PD multipliers into the result register.
// Revolutions are tracked incrementally on every hall step, so a tick needs
// no divider. Config writes are always ready and take effect on the next
// processed request; write them only while the block is idle.
module bldc_commutation_position_control (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata fields from bit 0: hall_bits[2:0], zero padding
  input  logic [bcpc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // tuser fields from bit 0: mode
  input  logic                               s_axis_tuser,
  // master stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata fields from bit 0: drive_pattern[5:0], pulse_width[21:6],
  // rotor_state[24:22], step_position[56:25], reverse_dir[57], zero padding
  output logic [bcpc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // tuser fields from bit 0: hall_fault
  output logic                               m_axis_tuser,
  // config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bcpc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bcpc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import bcpc_pkg::*;

  localparam int P = POSITION_WIDTH;

  cfg_t        cfg_q;
  logic        in_valid_q;
  mode_e       in_mode_q;
  logic [2:0]  in_hall_q;
  logic        out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;
  logic        out_fault_q;

  logic        advance;
  logic        is_tick;
  logic [2:0]  sector_dec;
  logic        hall_ok;
  pos_t        pos;
  pd_t         pd;

  logic [5:0]  res_pattern;
  logic [15:0] res_width;
  logic [2:0]  res_rotor;
  logic        res_rev;
  logic        res_fault;
  logic signed [P+31:0] step_ext;

  // Config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin <= '0;
      cfg_q.target <= '0;
      cfg_q.kp     <= KP_RESET;
      cfg_q.kd     <= KD_RESET;
      cfg_q.limit  <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ORIGIN: cfg_q.origin <= cfg_data_i[2:0];
        CFG_TARGET: cfg_q.target <= cfg_data_i;
        CFG_KP:     cfg_q.kp     <= cfg_data_i[7:0];
        CFG_KD:     cfg_q.kd     <= cfg_data_i[7:0];
        CFG_LIMIT:  cfg_q.limit  <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Input register and handshake
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q <= mode_e'(s_axis_tuser);
      in_hall_q <= s_axis_tdata[2:0];
    end
  end

  // Decode and state update
  assign is_tick    = (in_mode_q == MODE_TICK);
  assign sector_dec = hall_sector(in_hall_q);
  assign hall_ok    = (sector_dec != SECTOR_INVALID);

  bcpc_pos_track u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (advance && !is_tick && hall_ok),
    .sector_i (sector_dec),
    .pos_o    (pos)
  );

  bcpc_pd_loop u_pd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (advance && is_tick),
    .revs_i (pos.revs),
    .cfg_i  (cfg_q),
    .pd_o   (pd)
  );

  // Result selection
  always_comb begin
    res_fault = 1'b0;
    if (is_tick) begin
      res_rotor   = pos.last_rotor;
      res_rev     = pd.reverse_new;
      res_width   = pd.torque_new;
      res_pattern = pattern_for(pos.last_rotor, cfg_q.origin, pd.reverse_new);
    end else if (hall_ok) begin
      res_rotor   = sector_dec;
      res_rev     = pd.reverse_cur;
      res_width   = pd.torque_cur;
      res_pattern = pattern_for(sector_dec, cfg_q.origin, pd.reverse_cur);
    end else begin
      // bad hall code: drive off
      res_rotor   = SECTOR_INVALID;
      res_rev     = pd.reverse_cur;
      res_width   = '0;
      res_pattern = '0;
      res_fault   = 1'b1;
    end
    step_ext = (P + 32)'($signed(pos.step_next));
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q  <= {6'b0, res_rev, step_ext[31:0], res_rotor, res_width, res_pattern};
      out_fault_q <= res_fault;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_fault_q;

endmodule

FILE: hw/rtl/bcpc_checker.sv
// Port-level assertions for the BLDC commutation block and their bind.
module bcpc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bcpc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic                            m_axis_tuser
);
  import bcpc_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // A faulted result has the drive off and the invalid sector
  a_fault_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[5:0] == 6'd0 && m_axis_tdata[21:6] == 16'd0 &&
      m_axis_tdata[24:22] == SECTOR_INVALID)
    else $error("faulted result still drives phases");

  // A good result names a real sector and closes exactly one high and one low side
  a_good_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[24:22] <= 3'd5 && $countones(m_axis_tdata[5:0]) == 2)
    else $error("bad sector or phase pattern");

endmodule

bind bldc_commutation_position_control bcpc_checker u_bcpc_checker (.*);

FILE: dv/tb_bldc_commutation_position_control.sv
// Self-checking testbench for the six-step commutator with PD position loop.
module tb_bldc_commutation_position_control;
  timeunit 1ns;
  timeprecision 1ps;

  import bcpc_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_CYCLES  = 8;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int PHASES         = 6;
  localparam int PHASE_REQUESTS = 190;

  // Hall codes that no rotor sector produces
  localparam logic [2:0] HALL_ALL_LOW  = 3'b000;
  localparam logic [2:0] HALL_ALL_HIGH = 3'b111;

  // One drive result as the block reports it
  typedef struct packed {
    logic [5:0]                pattern;
    logic [15:0]               width;
    logic [2:0]                rotor;
    logic [POSITION_WIDTH-1:0] steps;
    logic                      reverse;
    logic                      fault;
  } drive_out_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Motor model state and register copies
  logic [2:0]                rotor_seen;
  logic [POSITION_WIDTH-1:0] step_tally;
  longint                    last_err;
  logic                      lead_reversed;
  logic [15:0]               torque_now;
  logic [2:0]                origin_reg;
  logic [15:0]               target_reg;
  logic [7:0]                kp_reg;
  logic [7:0]                kd_reg;
  logic [15:0]               limit_reg;

  drive_out_t drive_outputs_q[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         stall_left = 0;
  bit         gaps_on = 1'b1;
  bit         stalls_on = 1'b1;

  bldc_commutation_position_control i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Idle length: mostly none, often short, now and then long
  function automatic int idle_length(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Phase switches for a rotor sector with the current lead and origin
  function automatic logic [5:0] commutation_for(input logic [2:0] sector);
    int         drive_state;
    logic [5:0] sw;
    drive_state = int'(sector) + 2 * SECTORS - int'(origin_reg);
    drive_state = lead_reversed ? drive_state - 2 : drive_state + 2;
    case (drive_state % SECTORS)
      0:       sw = 6'h12;
      1:       sw = 6'h18;
      2:       sw = 6'h09;
      3:       sw = 6'h21;
      4:       sw = 6'h24;
      default: sw = 6'h06;
    endcase
    return sw;
  endfunction

  // Advance the motor model by one request and return its drive result
  function automatic drive_out_t advance_motor_model(input mode_e mode,
                                                     input logic [2:0] hall);
    logic [2:0] sector;
    int         step_gap;
    longint     revs, err, de, torque, mag;
    drive_out_t res;
    res = '0;
    if (mode == MODE_HALL) begin
      case (hall)
        3'd1:    sector = 3'd5;
        3'd2:    sector = 3'd3;
        3'd3:    sector = 3'd4;
        3'd4:    sector = 3'd1;
        3'd5:    sector = 3'd0;
        3'd6:    sector = 3'd2;
        default: sector = SECTOR_INVALID;
      endcase
      if (sector == SECTOR_INVALID) begin
        // drive off, position untouched
        res.fault = 1'b1;
        res.rotor = SECTOR_INVALID;
      end else begin
        // shortest signed distance, ties of three count forward
        step_gap = (int'(sector) + SECTORS - int'(rotor_seen)) % SECTORS;
        if (step_gap <= 3) step_tally = step_tally + POSITION_WIDTH'(step_gap);
        else step_tally = step_tally - POSITION_WIDTH'(SECTORS - step_gap);
        rotor_seen  = sector;
        res.rotor   = sector;
        res.pattern = commutation_for(sector);
        res.width   = torque_now;
      end
    end else begin
      // PD loop on whole revolutions, truncated toward zero
      revs     = longint'($signed(step_tally)) / SECTORS;
      err      = longint'($signed(target_reg)) - revs;
      de       = (err - last_err) * DERIV_SCALE;
      last_err = err;
      torque   = longint'(kp_reg) * err + longint'(kd_reg) * de;
      lead_reversed = (torque < 0);
      mag = lead_reversed ? -torque : torque;
      if (mag > longint'(limit_reg)) mag = longint'(limit_reg);
      torque_now  = mag[15:0];
      res.rotor   = rotor_seen;
      res.pattern = commutation_for(rotor_seen);
      res.width   = torque_now;
    end
    res.steps   = step_tally;
    res.reverse = lead_reversed;
    return res;
  endfunction

  // Send one request after a random gap and record its predicted result
  task automatic send_request(input mode_e mode, input logic [2:0] hall);
    int gap;
    gap = idle_length(gaps_on);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= S_TDATA_W'(hall);
    do @(posedge clk_i); while (!s_axis_tready);
    drive_outputs_q.push_back(advance_motor_model(mode, hall));
  endtask

  // Hold off the sender until every result is out and the pipe is empty
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (drive_outputs_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; valid stays high for a following write
  task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ORIGIN: origin_reg = value[2:0];
      CFG_TARGET: target_reg = value;
      CFG_KP:     kp_reg     = value[7:0];
      CFG_KD:     kd_reg     = value[7:0];
      CFG_LIMIT:  limit_reg  = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] origin, input logic [15:0] target,
                           input logic [15:0] kp, input logic [15:0] kd,
                           input logic [15:0] limit);
    program_register(CFG_ORIGIN, origin);
    program_register(CFG_TARGET, target);
    program_register(CFG_KP, kp);
    program_register(CFG_KD, kd);
    program_register(CFG_LIMIT, limit);
    cfg_valid_i <= 1'b0;
  endtask

  // Zero, the top of the field, or anything
  function automatic logic [15:0] pick_raw(input logic [15:0] top);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return top;
    return 16'($urandom);
  endfunction

  // Sector decode, invalid codes and every signed step distance at reset gains
  task automatic test_hall_decode();
    send_request(MODE_TICK, 3'($urandom));   // at rest on target
    send_request(MODE_HALL, 3'd5);           // sector 0, no motion
    send_request(MODE_HALL, 3'd4);           // +1
    send_request(MODE_HALL, 3'd6);           // +1
    send_request(MODE_HALL, 3'd3);           // skipped sector, +2
    send_request(MODE_HALL, 3'd4);           // half turn, counts +3
    send_request(MODE_HALL, 3'd3);           // +3 again
    send_request(MODE_HALL, 3'd6);           // distance four, -2
    send_request(MODE_HALL, 3'd4);           // distance five, -1
    send_request(MODE_HALL, HALL_ALL_LOW);   // invalid
    send_request(MODE_HALL, HALL_ALL_HIGH);  // invalid
    send_request(MODE_TICK, HALL_ALL_HIGH);  // hall field ignored, goes reverse
    send_request(MODE_HALL, 3'd2);           // commutation with reverse lead
    send_request(MODE_HALL, 3'd1);
  endtask

  // Gain, target and limit extremes, origins past five
  task automatic test_control_ticks();
    settle_block();
    configure(16'hFFFF, 16'h7FFF, 16'h00FF, 16'h00FF, 16'hFFFF);
    send_request(MODE_TICK, 3'($urandom));   // saturates forward
    send_request(MODE_TICK, 3'($urandom));   // no derivative term
    send_request(MODE_HALL, 3'd5);
    settle_block();
    configure(16'h0006, 16'h8000, 16'h00FF, 16'h00FF, 16'h0000);
    send_request(MODE_TICK, 3'($urandom));   // zero limit
    send_request(MODE_HALL, 3'd4);
    settle_block();
    configure(16'h0000, 16'h0000, 16'(KP_RESET), 16'(KD_RESET), LIMIT_RESET);
    send_request(MODE_TICK, 3'($urandom));
  endtask

  // Writes past the last register must leave everything alone
  task automatic test_bad_register_index();
    settle_block();
    for (int i = int'(CFG_LIMIT) + 1; i < (1 << CFG_IDX_W); i++) begin
      program_register(CFG_IDX_W'(i), 16'($urandom));
    end
    cfg_valid_i <= 1'b0;
    send_request(MODE_TICK, 3'($urandom));
    send_request(MODE_HALL, 3'd6);
  endtask

  // Random rotor motion in runs, with ticks and glitches, across settings
  task automatic test_random_motion();
    int          r;
    int          delta;
    bit          spin_fwd;
    logic [2:0]  sector;
    logic [2:0]  hall;
    logic [15:0] tgt;
    spin_fwd = 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      settle_block();
      gaps_on   = (p != 2);
      stalls_on = (p != 2);
      // targets mostly near the shaft so the torque changes sign
      r = $urandom_range(0, 99);
      if (r < 55)      tgt = 16'(int'($urandom_range(0, 20)) - 10);
      else if (r < 75) tgt = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      else             tgt = 16'($urandom);
      configure(16'($urandom), tgt, pick_raw(16'h00FF), pick_raw(16'h00FF),
                pick_raw(16'hFFFF));
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (p == 1 && n == PHASE_REQUESTS / 2) settle_block();
        r = $urandom_range(0, 99);
        if (r < 20) begin
          send_request(MODE_TICK, 3'($urandom));
        end else if (r < 27) begin
          send_request(MODE_HALL, $urandom_range(0, 1) ? HALL_ALL_HIGH : HALL_ALL_LOW);
        end else begin
          if ($urandom_range(0, 99) < 5) spin_fwd = !spin_fwd;
          r = $urandom_range(0, 99);
          if (r < 80)      delta = 1;
          else if (r < 92) delta = $urandom_range(2, 3);
          else             delta = $urandom_range(0, 5);
          if (r < 92 && !spin_fwd) delta = -delta;
          sector = 3'((int'(rotor_seen) + SECTORS + delta) % SECTORS);
          case (sector)
            3'd0:    hall = 3'd5;
            3'd1:    hall = 3'd4;
            3'd2:    hall = 3'd6;
            3'd3:    hall = 3'd2;
            3'd4:    hall = 3'd3;
            default: hall = 3'd1;
          endcase
          send_request(MODE_HALL, hall);
        end
      end
    end
  endtask

  // Random back-pressure on the result side
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left = idle_length(stalls_on);
      m_axis_tready <= (stall_left == 0);
    end
  end

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_drive
    drive_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (drive_outputs_q.size() == 0) begin
        $error("result with no request pending: tdata 'h%0h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = drive_outputs_q.pop_front();
        compare_field("drive_pattern", 32'(want.pattern), 32'(m_axis_tdata[5:0]));
        compare_field("pulse_width", 32'(want.width), 32'(m_axis_tdata[21:6]));
        compare_field("rotor_state", 32'(want.rotor), 32'(m_axis_tdata[24:22]));
        compare_field("step_position", want.steps, m_axis_tdata[56:25]);
        compare_field("reverse_dir", 32'(want.reverse), 32'(m_axis_tdata[57]));
        compare_field("hall_fault", 32'(want.fault), 32'(m_axis_tuser));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_bldc_commutation_position_control failed");
      $finish;
    end
  end

  initial begin
    rotor_seen    = '0;
    step_tally    = '0;
    last_err      = 0;
    lead_reversed = 1'b0;
    torque_now    = '0;
    origin_reg    = '0;
    target_reg    = '0;
    kp_reg        = KP_RESET;
    kd_reg        = KD_RESET;
    limit_reg     = LIMIT_RESET;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_hall_decode();
    test_control_ticks();
    test_bad_register_index();
    test_random_motion();

    settle_block();
    if (mismatch_count == 0) begin
      $display("tb_bldc_commutation_position_control passed");
    end else begin
      $display("tb_bldc_commutation_position_control failed");
    end
    $finish;
  end

endmodule
